### hdl/bls_pkg.sv
// Shared types and constants for the brake lamp sequencer.
package bls_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CFG_W           = 16;
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_W-1:0] OFF_HOLD_RST   = 16'd4000;
	localparam logic [CFG_W-1:0] ANIM_FIRST_RST = 16'd200;
	localparam logic [CFG_W-1:0] ANIM_STEP_RST  = 16'd100;
	localparam logic [CFG_W-1:0] ALT_HALF_RST   = 16'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFF_HOLD   = 2'd0,
		REG_ANIM_FIRST = 2'd1,
		REG_ANIM_STEP  = 2'd2,
		REG_ALT_HALF   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_ON  = 2'd1,
		MODE_ALT = 2'd2
	} lamp_mode_t;

	typedef enum logic [3:0] {
		PH_OFF    = 4'd0,
		PH_FIRST  = 4'd1,
		PH_STEP1  = 4'd2,
		PH_STEP2  = 4'd3,
		PH_STEP3  = 4'd4,
		PH_STEP4  = 4'd5,
		PH_STEADY = 4'd6,
		PH_ALT_R  = 4'd7,
		PH_ALT_L  = 4'd8
	} phase_t;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] off_hold;
		logic [CFG_W-1:0] anim_first;
		logic [CFG_W-1:0] anim_step;
		logic [CFG_W-1:0] alt_half;
	} cfg_t;

	typedef struct packed {
		lamp_mode_t mode;
		phase_t     phase;
	} ctrl_t;

endpackage

### hdl/bls_if.sv
// Valid/ready channel interfaces for lamp requests and lamp results.
interface bls_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [1:0] requested_state;

	modport source (output valid, output mode, output requested_state, input ready);
	modport sink (input valid, input mode, input requested_state, output ready);
endinterface

interface bls_lamp_if;
	logic valid;
	logic ready;
	logic left_lamp;
	logic right_lamp;

	modport source (output valid, output left_lamp, output right_lamp, input ready);
	modport sink (input valid, input left_lamp, input right_lamp, output ready);
endinterface

### hdl/brake_lamp_sequencer_unit.sv
// Top level of the brake lamp sequencer: state, config and result register.
//
//   channel   dir   payload                    handshake
//   item      in    mode, requested_state      valid/ready
//   result    out   left_lamp, right_lamp      valid/ready
//   cfg       in    cfg_index, cfg_wdata       cfg_we, no back-pressure
//
// When a beat is taken, the step logic updates the mode, phase and both
// countdowns and loads the lamp pair into the result register.
// One beat per cycle is sustained while the result side takes a beat each cycle.
// A result waiting in the register still lets a beat in if it leaves that cycle.
// Reset clears mode and phase and loads the config defaults and the off hold.
module brake_lamp_sequencer_unit #(
	parameter int TIMER_WIDTH = bls_pkg::TIMER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bls_item_if.sink                    item,
	bls_lamp_if.source                  result,
	input  logic                        cfg_we,
	input  logic [bls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bls_pkg::CFG_W-1:0]   cfg_wdata
);
	import bls_pkg::*;

	localparam logic [31:0] TMR_MAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
	localparam logic [TIMER_WIDTH-1:0] HOLD_RST =
		(32'(OFF_HOLD_RST) > TMR_MAX32) ? TIMER_WIDTH'(TMR_MAX32)
		                                : TIMER_WIDTH'(OFF_HOLD_RST);

	cfg_t                   cfg_q;
	ctrl_t                  ctrl_q, ctrl_nxt;
	logic [TIMER_WIDTH-1:0] phase_cnt_q, phase_cnt_nxt;
	logic [TIMER_WIDTH-1:0] hold_cnt_q, hold_cnt_nxt;
	logic                   left_nxt, right_nxt;
	logic                   out_valid_q, left_q, right_q;
	logic                   accept;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign result.valid      = out_valid_q;
	assign result.left_lamp  = left_q;
	assign result.right_lamp = right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_hold   <= OFF_HOLD_RST;
			cfg_q.anim_first <= ANIM_FIRST_RST;
			cfg_q.anim_step  <= ANIM_STEP_RST;
			cfg_q.alt_half   <= ALT_HALF_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_OFF_HOLD:   cfg_q.off_hold   <= cfg_wdata;
				REG_ANIM_FIRST: cfg_q.anim_first <= cfg_wdata;
				REG_ANIM_STEP:  cfg_q.anim_step  <= cfg_wdata;
				REG_ALT_HALF:   cfg_q.alt_half   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bls_step #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_step (
		.ctrl          (ctrl_q),
		.phase_cnt     (phase_cnt_q),
		.hold_cnt      (hold_cnt_q),
		.cfg           (cfg_q),
		.kind          (item.mode),
		.req           (item.requested_state),
		.ctrl_nxt      (ctrl_nxt),
		.phase_cnt_nxt (phase_cnt_nxt),
		.hold_cnt_nxt  (hold_cnt_nxt),
		.left_nxt      (left_nxt),
		.right_nxt     (right_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.mode  <= MODE_OFF;
			ctrl_q.phase <= PH_OFF;
			phase_cnt_q  <= '0;
			hold_cnt_q   <= HOLD_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				ctrl_q      <= ctrl_nxt;
				phase_cnt_q <= phase_cnt_nxt;
				hold_cnt_q  <= hold_cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				// drop the beat once taken
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= left_nxt;
			right_q <= right_nxt;
		end
	end

endmodule

### hdl/bls_step.sv
// Next-state and lamp decode logic for one request or tick beat.
module bls_step #(
	parameter int TIMER_WIDTH = bls_pkg::TIMER_WIDTH_DEF
) (
	input  bls_pkg::ctrl_t           ctrl,
	input  logic [TIMER_WIDTH-1:0]   phase_cnt,
	input  logic [TIMER_WIDTH-1:0]   hold_cnt,
	input  bls_pkg::cfg_t            cfg,
	input  logic                     kind,
	input  logic [1:0]               req,
	output bls_pkg::ctrl_t           ctrl_nxt,
	output logic [TIMER_WIDTH-1:0]   phase_cnt_nxt,
	output logic [TIMER_WIDTH-1:0]   hold_cnt_nxt,
	output logic                     left_nxt,
	output logic                     right_nxt
);
	import bls_pkg::*;

	localparam logic [31:0] TMR_MAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

	function automatic logic [TIMER_WIDTH-1:0] clamp(input logic [CFG_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 > TMR_MAX32)
			return TIMER_WIDTH'(TMR_MAX32);
		return TIMER_WIDTH'(v32);
	endfunction

	logic timed;

	always_comb begin
		ctrl_nxt      = ctrl;
		phase_cnt_nxt = phase_cnt;
		hold_cnt_nxt  = hold_cnt;
		timed = (ctrl.phase inside {[PH_FIRST:PH_STEP4], PH_ALT_R, PH_ALT_L});

		if (kind == KIND_TICK) begin
			if (hold_cnt != '0)
				hold_cnt_nxt = hold_cnt - 1'b1;
			if (timed) begin
				if (phase_cnt <= TIMER_WIDTH'(1)) begin
					// advance on the tick that expires the phase
					case (ctrl.phase)
						PH_FIRST: begin
							ctrl_nxt.phase = PH_STEP1;
							phase_cnt_nxt  = clamp(cfg.anim_step);
						end
						PH_STEP1: begin
							ctrl_nxt.phase = PH_STEP2;
							phase_cnt_nxt  = clamp(cfg.anim_step);
						end
						PH_STEP2: begin
							ctrl_nxt.phase = PH_STEP3;
							phase_cnt_nxt  = clamp(cfg.anim_step);
						end
						PH_STEP3: begin
							ctrl_nxt.phase = PH_STEP4;
							phase_cnt_nxt  = clamp(cfg.anim_step);
						end
						PH_STEP4: begin
							ctrl_nxt.phase = PH_STEADY;
							phase_cnt_nxt  = '0;
						end
						PH_ALT_R: begin
							ctrl_nxt.phase = PH_ALT_L;
							phase_cnt_nxt  = clamp(cfg.alt_half);
						end
						PH_ALT_L: begin
							ctrl_nxt.phase = PH_ALT_R;
							phase_cnt_nxt  = clamp(cfg.alt_half);
						end
						default: begin
							phase_cnt_nxt = '0;
						end
					endcase
				end else begin
					phase_cnt_nxt = phase_cnt - 1'b1;
				end
			end
		end else if (req <= MODE_ALT && req != ctrl.mode) begin
			// a new mode restarts its sequence; unknown codes drop
			ctrl_nxt.mode = lamp_mode_t'(req);
			case (lamp_mode_t'(req))
				MODE_OFF: begin
					ctrl_nxt.phase = PH_OFF;
					phase_cnt_nxt  = '0;
					hold_cnt_nxt   = clamp(cfg.off_hold);
				end
				MODE_ON: begin
					if (hold_cnt == '0) begin
						ctrl_nxt.phase = PH_FIRST;
						phase_cnt_nxt  = clamp(cfg.anim_first);
					end else begin
						ctrl_nxt.phase = PH_STEADY;
						phase_cnt_nxt  = '0;
					end
				end
				default: begin
					ctrl_nxt.phase = PH_ALT_R;
					phase_cnt_nxt  = clamp(cfg.alt_half);
				end
			endcase
		end

		case (ctrl_nxt.phase)
			PH_FIRST, PH_STEADY: begin
				left_nxt  = 1'b1;
				right_nxt = 1'b1;
			end
			PH_STEP1, PH_STEP3, PH_ALT_R: begin
				left_nxt  = 1'b0;
				right_nxt = 1'b1;
			end
			PH_STEP2, PH_STEP4, PH_ALT_L: begin
				left_nxt  = 1'b1;
				right_nxt = 1'b0;
			end
			default: begin
				left_nxt  = 1'b0;
				right_nxt = 1'b0;
			end
		endcase
	end

endmodule

### tb/sv/tb_brake_lamp_sequencer_unit.sv
// Testbench for the brake lamp sequencer: random ticks and requests checked against a predictor.
`timescale 1ns / 100ps

module tb_brake_lamp_sequencer_unit;
	import bls_pkg::*;

	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int         LONG_HOLD   = 60;

	typedef struct packed {
		logic left;
		logic right;
	} lamp_pair_t;

	// Tracks the lamp sequence and holds the lamp pairs still owed by the block.
	class lamp_tracker;
		cfg_t                 regs;
		lamp_mode_t           cur_mode;
		phase_t               cur_phase;
		logic [CFG_W-1:0]     phase_left;
		logic [CFG_W-1:0]     hold_left;
		lamp_pair_t           lamps_due[$];
		int                   errors;

		function new();
			regs.off_hold   = OFF_HOLD_RST;
			regs.anim_first = ANIM_FIRST_RST;
			regs.anim_step  = ANIM_STEP_RST;
			regs.alt_half   = ALT_HALF_RST;
			cur_mode        = MODE_OFF;
			cur_phase       = PH_OFF;
			phase_left      = '0;
			hold_left       = OFF_HOLD_RST;
			errors          = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_OFF_HOLD:   regs.off_hold   = val;
				REG_ANIM_FIRST: regs.anim_first = val;
				REG_ANIM_STEP:  regs.anim_step  = val;
				REG_ALT_HALF:   regs.alt_half   = val;
				default: ;
			endcase
		endfunction

		// Advance the lamp state by one accepted beat and queue the lamp pair it yields.
		function void note_item(logic kind, logic [1:0] req);
			lamp_pair_t lamps;
			bit timed;
			if (kind == KIND_TICK) begin
				if (hold_left != 0)
					hold_left--;
				timed = (cur_phase >= PH_FIRST && cur_phase <= PH_STEP4) ||
					cur_phase == PH_ALT_R || cur_phase == PH_ALT_L;
				if (timed) begin
					if (phase_left <= 1) begin
						phase_left = '0;
						case (cur_phase)
							PH_FIRST: begin
								cur_phase = PH_STEP1; phase_left = regs.anim_step;
							end
							PH_STEP1: begin
								cur_phase = PH_STEP2; phase_left = regs.anim_step;
							end
							PH_STEP2: begin
								cur_phase = PH_STEP3; phase_left = regs.anim_step;
							end
							PH_STEP3: begin
								cur_phase = PH_STEP4; phase_left = regs.anim_step;
							end
							PH_STEP4: begin
								cur_phase = PH_STEADY; phase_left = '0;
							end
							PH_ALT_R: begin
								cur_phase = PH_ALT_L; phase_left = regs.alt_half;
							end
							PH_ALT_L: begin
								cur_phase = PH_ALT_R; phase_left = regs.alt_half;
							end
							default: ;
						endcase
					end else begin
						phase_left--;
					end
				end
			end else if (req <= MODE_ALT && req != cur_mode) begin
				cur_mode = lamp_mode_t'(req);
				// restart the sequence of the new mode
				case (cur_mode)
					MODE_OFF: begin
						cur_phase  = PH_OFF;
						phase_left = '0;
						hold_left  = regs.off_hold;
					end
					MODE_ON: begin
						if (hold_left == 0) begin
							cur_phase  = PH_FIRST;
							phase_left = regs.anim_first;
						end else begin
							cur_phase  = PH_STEADY;
							phase_left = '0;
						end
					end
					default: begin
						cur_phase  = PH_ALT_R;
						phase_left = regs.alt_half;
					end
				endcase
			end
			case (cur_phase)
				PH_FIRST, PH_STEADY:          lamps = '{left: 1'b1, right: 1'b1};
				PH_STEP1, PH_STEP3, PH_ALT_R: lamps = '{left: 1'b0, right: 1'b1};
				PH_STEP2, PH_STEP4, PH_ALT_L: lamps = '{left: 1'b1, right: 1'b0};
				default:                      lamps = '{left: 1'b0, right: 1'b0};
			endcase
			lamps_due.push_back(lamps);
		endfunction

		function void check_lamps(logic left, logic right);
			lamp_pair_t want;
			if (lamps_due.size() == 0) begin
				$error("lamp beat with nothing pending: left_lamp %0b right_lamp %0b",
					left, right);
				errors++;
				return;
			end
			want = lamps_due.pop_front();
			if (left !== want.left) begin
				$error("left_lamp: expected %0b, got %0b", want.left, left);
				errors++;
			end
			if (right !== want.right) begin
				$error("right_lamp: expected %0b, got %0b", want.right, right);
				errors++;
			end
		endfunction

		function int pending();
			return lamps_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bls_item_if item_ch();
	bls_lamp_if lamp_ch();

	lamp_tracker tracker = new();
	int          burst_left;
	bit          hold_off_req;

	brake_lamp_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (lamp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Check results before noting inputs: a result never belongs to a beat taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (lamp_ch.valid && lamp_ch.ready)
				tracker.check_lamps(lamp_ch.left_lamp, lamp_ch.right_lamp);
			if (item_ch.valid && item_ch.ready)
				tracker.note_item(item_ch.mode, item_ch.requested_state);
		end
	end

	// Result side: stall on a random pattern, or hold off for a long stretch on request.
	initial begin : lamp_receiver
		int          pos;
		int          stall_left;
		logic [31:0] pattern;
		pos        = 0;
		stall_left = 0;
		pattern    = '1;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				lamp_ch.ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left   = LONG_HOLD - 1;
				lamp_ch.ready <= 1'b0;
			end else begin
				if (pos == 0) begin
					case ($urandom_range(0, 3))
						0:       pattern = '1;
						1:       pattern = $urandom;
						2:       pattern = $urandom | $urandom;
						default: pattern = $urandom & $urandom;
					endcase
				end
				lamp_ch.ready <= pattern[pos];
				pos = (pos + 1) % 32;
			end
		end
	end

	// Offer one beat and hold it until taken; open a new burst after a random gap.
	task automatic send_item(input logic kind, input logic [1:0] req);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid           <= 1'b1;
		item_ch.mode            <= kind;
		item_ch.requested_state <= req;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic drain_lamps();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		tracker.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_W-1:0] off_hold, anim_first,
		anim_step, alt_half);
		write_reg(REG_OFF_HOLD, off_hold);
		write_reg(REG_ANIM_FIRST, anim_first);
		write_reg(REG_ANIM_STEP, anim_step);
		write_reg(REG_ALT_HALF, alt_half);
		cfg_we <= 1'b0;
	endtask

	// Mostly ticks with requests mixed in; midway either stall the result side or drain.
	task automatic run_random(input int count, input bit long_hold);
		int r;
		int s;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				if (long_hold) begin
					hold_off_req = 1'b1;
					burst_left   = 16;
				end else begin
					drain_lamps();
				end
			end
			r = $urandom_range(0, 99);
			if (r < 76) begin
				send_item(KIND_TICK, 2'($urandom_range(0, 3)));
			end else begin
				s = $urandom_range(0, 7);
				if (s == 7)
					send_item(KIND_REQUEST, REQ_UNKNOWN);
				else
					send_item(KIND_REQUEST, 2'(s % 3));
			end
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_duration();
		if ($urandom_range(0, 7) == 0)
			return CFG_W'($urandom_range(0, 65535));
		return CFG_W'($urandom_range(0, 12));
	endfunction

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = '0;
		cfg_wdata               = '0;
		item_ch.valid           = 1'b0;
		item_ch.mode            = KIND_TICK;
		item_ch.requested_state = '0;
		lamp_ch.ready           = 1'b0;
		burst_left              = 0;
		hold_off_req            = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// default durations: hold not expired, so on goes straight to steady
		send_item(KIND_TICK, REQ_UNKNOWN);
		send_item(KIND_TICK, MODE_OFF);
		send_item(KIND_REQUEST, MODE_OFF);
		send_item(KIND_REQUEST, REQ_UNKNOWN);
		send_item(KIND_REQUEST, MODE_ON);
		send_item(KIND_TICK, MODE_ON);
		send_item(KIND_REQUEST, MODE_ON);
		send_item(KIND_REQUEST, MODE_ALT);
		send_item(KIND_TICK, MODE_ALT);
		send_item(KIND_TICK, MODE_OFF);
		send_item(KIND_REQUEST, MODE_OFF);
		drain_lamps();

		// short hold, zero step: play the whole animation, then alternate
		program_regs(16'd2, 16'd1, 16'd0, 16'd1);
		send_item(KIND_REQUEST, MODE_ON);
		send_item(KIND_REQUEST, MODE_OFF);
		repeat (2) send_item(KIND_TICK, MODE_OFF);
		send_item(KIND_REQUEST, MODE_ON);
		repeat (6) send_item(KIND_TICK, MODE_OFF);
		send_item(KIND_REQUEST, MODE_ALT);
		repeat (2) send_item(KIND_TICK, REQ_UNKNOWN);
		drain_lamps();

		program_regs(16'd0, 16'd0, 16'd0, 16'd0);
		run_random(150, 1'b1);
		drain_lamps();
		program_regs(16'd1, 16'd1, 16'd1, 16'd1);
		run_random(150, 1'b0);
		drain_lamps();
		program_regs(16'd3, 16'd2, 16'd1, 16'd4);
		run_random(150, 1'b1);
		drain_lamps();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(60, 1'b0);
		drain_lamps();
		program_regs(16'd6, 16'd3, 16'd2, 16'd5);
		run_random(150, 1'b1);
		for (int p = 0; p < 5; p++) begin
			drain_lamps();
			program_regs(pick_duration(), pick_duration(), pick_duration(), pick_duration());
			run_random(138, p[0]);
		end

		drain_lamps();
		repeat (5) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
